/* rtl/lpf_pkg.sv */
// Shared types and constants for the lidar point filter.
// No dependencies; imported by lpf_regs and lidar_point_filter.
package lpf_pkg;

    // Register file
    localparam int ADDR_W = 4;
    localparam logic [1:0] REG_KEEP_EVERY   = 2'd0;
    localparam logic [1:0] REG_BLIND_RADIUS = 2'd1;
    localparam logic [1:0] REG_Z_UPPER      = 2'd2;
    localparam logic [1:0] REG_Z_LOWER      = 2'd3;

    localparam logic [7:0]         KEEP_EVERY_RST   = 8'd1;
    localparam logic [30:0]        BLIND_RADIUS_RST = 31'd655;
    localparam logic signed [31:0] Z_UPPER_RST      = 32'sd65536;
    localparam logic signed [31:0] Z_LOWER_RST      = -32'sd65536;

    // Frame indexing and relative time
    localparam int          MAX_FRAME_POINTS = 65535;
    localparam logic [15:0] INDEX_LAST       = 16'(MAX_FRAME_POINTS - 1);
    localparam int          TIME_W           = 23;
    localparam logic [TIME_W-1:0] TIME_FULL_SCALE = 23'd6553600;

    typedef struct packed {
        logic [7:0]         keep_every;
        logic [30:0]        blind_radius;
        logic signed [31:0] z_upper;
        logic signed [31:0] z_lower;
    } lpf_cfg_t;

endpackage

/* rtl/lpf_regs.sv */
// APB register file for the lidar point filter configuration.
// Depends on lpf_pkg for register indexes, reset values and lpf_cfg_t.
module lpf_regs (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [lpf_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    output lpf_pkg::lpf_cfg_t         cfg
);
    import lpf_pkg::*;

    lpf_cfg_t   cfg_reg;
    logic       wr_en;
    logic [1:0] reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = paddr[3:2];
    assign wr_en   = psel & penable & pwrite & pready;
    assign cfg     = cfg_reg;

    // register writes on the access phase
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.keep_every   <= KEEP_EVERY_RST;
            cfg_reg.blind_radius <= BLIND_RADIUS_RST;
            cfg_reg.z_upper      <= Z_UPPER_RST;
            cfg_reg.z_lower      <= Z_LOWER_RST;
        end else if (wr_en) begin
            case (reg_sel)
                REG_KEEP_EVERY:   cfg_reg.keep_every   <= pwdata[7:0];
                REG_BLIND_RADIUS: cfg_reg.blind_radius <= pwdata[30:0];
                REG_Z_UPPER:      cfg_reg.z_upper      <= signed'(pwdata);
                REG_Z_LOWER:      cfg_reg.z_lower      <= signed'(pwdata);
                default:          cfg_reg <= cfg_reg;
            endcase
        end
    end

    // read mux
    always_comb begin
        case (reg_sel)
            REG_KEEP_EVERY:   prdata = {24'd0, cfg_reg.keep_every};
            REG_BLIND_RADIUS: prdata = {1'b0, cfg_reg.blind_radius};
            REG_Z_UPPER:      prdata = cfg_reg.z_upper;
            REG_Z_LOWER:      prdata = cfg_reg.z_lower;
            default:          prdata = 32'd0;
        endcase
    end

endmodule

/* rtl/lidar_point_filter.sv */
// Top level of the lidar point filter: decimation, blind radius and height band.
// Depends on lpf_pkg and lpf_regs.
//
// One point per transfer. The block keeps one point in keep_every, drops
// non-finite points, points inside the blind radius and points outside the
// height band, and tags each kept point with index*100/frame_points in Q7.16.
// The last point of a frame always yields a result with frame_end set.
// A point that fails decimation, finiteness or the band and is not the last
// of its frame is dropped in its accepting cycle. Such a point that closes a
// frame goes from the accepting cycle straight to the output register load.
// A point that passes those checks runs through all steps, also when the
// range check then drops it: the accepting cycle, the one shared 32x32
// multiplier (x*x, y*y, z*z, radius*radius, index*scale, then drain), the
// one-bit-per-cycle restoring divider, then the load of the output register.
// The load waits while an earlier result still sits unaccepted in the output
// register. The input is not ready while a point is in work; it is ready
// again while the last result still waits in the output register.
module lidar_point_filter (
    input  logic                       aclk,
    input  logic                       aresetn,
    // point input
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic signed [31:0]         s_x_coord,
    input  logic signed [31:0]         s_y_coord,
    input  logic signed [31:0]         s_z_coord,
    input  logic [31:0]                s_intensity_bits,
    input  logic                       s_coords_finite,
    input  logic [15:0]                s_frame_points,
    input  logic                       s_last_in_frame,
    // result output
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [31:0]         m_x_out,
    output logic signed [31:0]         m_y_out,
    output logic signed [31:0]         m_z_out,
    output logic [31:0]                m_intensity_out,
    output logic [lpf_pkg::TIME_W-1:0] m_rel_time,
    output logic                       m_point_kept,
    output logic                       m_frame_end,
    // configuration
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [lpf_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import lpf_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;
    localparam logic [4:0] MUL_LAST = 5'd5;
    localparam logic [4:0] DIV_LAST = 5'(TIME_W - 1);

    lpf_cfg_t cfg;

    lpf_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    function automatic logic [31:0] mag(input logic signed [31:0] v);
        mag = v[31] ? 32'(-v) : 32'(v);
    endfunction

    // control state
    logic [1:0]  state_reg, state_next;
    logic [4:0]  step_reg, step_next;
    logic [15:0] point_index_reg, point_index_next;
    logic [7:0]  phase_reg, phase_next;
    logic        kept_reg, kept_next;
    logic        last_reg, last_next;
    logic        m_valid_reg, m_valid_next;

    // datapath
    logic signed [31:0] x_reg, y_reg, z_reg;
    logic [31:0]        inten_reg;
    logic [15:0]        idx_reg, npts_reg;
    logic [63:0]        prod_reg, acc_reg, acc_next;
    logic [15:0]        rem_reg, rem_next;
    logic [TIME_W-1:0]  quo_reg, quo_next;
    logic [31:0]        op_a, op_b;

    // output register
    logic signed [31:0] m_x_reg, m_y_reg, m_z_reg;
    logic [31:0]        m_inten_reg;
    logic [TIME_W-1:0]  m_time_reg;
    logic               m_kept_reg, m_end_reg;

    logic              accept, candidate, keep_pre, load_out;
    logic [7:0]        factor;
    logic [16:0]       trial;
    logic              trial_ge;
    logic [TIME_W-1:0] rel_time;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid & s_ready;

    // decimation and point pre-checks
    assign factor    = (cfg.keep_every == 8'd0) ? 8'd1 : cfg.keep_every;
    assign candidate = ({1'b0, phase_reg} + 9'd1) >= {1'b0, factor};
    assign keep_pre  = candidate & s_coords_finite
                     & (s_z_coord <= cfg.z_upper) & (s_z_coord >= cfg.z_lower);

    // shared multiplier operand select
    always_comb begin
        case (step_reg)
            5'd0:    begin op_a = mag(x_reg); op_b = mag(x_reg); end
            5'd1:    begin op_a = mag(y_reg); op_b = mag(y_reg); end
            5'd2:    begin op_a = mag(z_reg); op_b = mag(z_reg); end
            5'd3:    begin
                op_a = {1'b0, cfg.blind_radius};
                op_b = {1'b0, cfg.blind_radius};
            end
            5'd4:    begin op_a = {16'd0, idx_reg}; op_b = 32'(TIME_FULL_SCALE); end
            default: begin op_a = 32'd0; op_b = 32'd0; end
        endcase
    end

    // divider step
    assign trial    = {rem_reg, quo_reg[TIME_W-1]};
    assign trial_ge = trial >= {1'b0, npts_reg};
    assign rel_time = (idx_reg >= npts_reg) ? TIME_FULL_SCALE : quo_reg;
    assign load_out = (state_reg == ST_OUT) & (!m_valid_reg | m_ready);

    // sequencer
    always_comb begin
        state_next       = state_reg;
        step_next        = step_reg;
        point_index_next = point_index_reg;
        phase_next       = phase_reg;
        kept_next        = kept_reg;
        last_next        = last_reg;
        acc_next         = acc_reg;
        rem_next         = rem_reg;
        quo_next         = quo_reg;
        m_valid_next     = m_valid_reg & ~m_ready;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    phase_next = candidate ? 8'd0 : phase_reg + 8'd1;
                    if (s_last_in_frame) begin
                        point_index_next = 16'd0;
                        phase_next       = 8'd0;
                    end else if (point_index_reg < INDEX_LAST) begin
                        point_index_next = point_index_reg + 16'd1;
                    end
                    kept_next = keep_pre;
                    last_next = s_last_in_frame;
                    acc_next  = 64'd0;
                    step_next = 5'd0;
                    if (keep_pre) begin
                        state_next = ST_MUL;
                    end else if (s_last_in_frame) begin
                        state_next = ST_OUT;
                    end
                end
            end
            ST_MUL: begin
                // consume the registered product of the previous step
                case (step_reg)
                    5'd1, 5'd2, 5'd3: acc_next = acc_reg + prod_reg;
                    5'd4: if (acc_reg < prod_reg) kept_next = 1'b0;
                    5'd5: begin
                        rem_next = prod_reg[38:23];
                        quo_next = prod_reg[22:0];
                    end
                    default: acc_next = acc_reg;
                endcase
                if (step_reg == MUL_LAST) begin
                    step_next  = 5'd0;
                    state_next = ST_DIV;
                end else begin
                    step_next = step_reg + 5'd1;
                end
            end
            ST_DIV: begin
                rem_next = trial_ge ? 16'(trial - {1'b0, npts_reg}) : trial[15:0];
                quo_next = {quo_reg[TIME_W-2:0], trial_ge};
                if (step_reg == DIV_LAST) begin
                    state_next = ST_OUT;
                end else begin
                    step_next = step_reg + 5'd1;
                end
            end
            ST_OUT: begin
                if (load_out) begin
                    m_valid_next = kept_reg | last_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            step_reg        <= 5'd0;
            point_index_reg <= 16'd0;
            phase_reg       <= 8'd0;
            kept_reg        <= 1'b0;
            last_reg        <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            step_reg        <= step_next;
            point_index_reg <= point_index_next;
            phase_reg       <= phase_next;
            kept_reg        <= kept_next;
            last_reg        <= last_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    // payload, arithmetic and output registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            x_reg     <= s_x_coord;
            y_reg     <= s_y_coord;
            z_reg     <= s_z_coord;
            inten_reg <= s_intensity_bits;
            idx_reg   <= point_index_reg;
            npts_reg  <= (s_frame_points == 16'd0) ? 16'd1 : s_frame_points;
        end
        prod_reg <= {32'd0, op_a} * {32'd0, op_b};
        acc_reg  <= acc_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        if (load_out) begin
            m_x_reg     <= kept_reg ? x_reg : 32'sd0;
            m_y_reg     <= kept_reg ? y_reg : 32'sd0;
            m_z_reg     <= kept_reg ? z_reg : 32'sd0;
            m_inten_reg <= kept_reg ? inten_reg : 32'd0;
            m_time_reg  <= kept_reg ? rel_time : '0;
            m_kept_reg  <= kept_reg;
            m_end_reg   <= last_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_x_out         = m_x_reg;
    assign m_y_out         = m_y_reg;
    assign m_z_out         = m_z_reg;
    assign m_intensity_out = m_inten_reg;
    assign m_rel_time      = m_time_reg;
    assign m_point_kept    = m_kept_reg;
    assign m_frame_end     = m_end_reg;

    // every result carries a point or closes a frame
    a_result_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_point_kept || m_frame_end))
        else $error("result with neither point_kept nor frame_end");

    // relative time stays within full scale
    a_time_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_rel_time <= TIME_FULL_SCALE))
        else $error("rel_time above full scale");

    // a frame's last point has already cleared the frame state
    a_frame_reset: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT && last_reg) |-> (point_index_reg == 16'd0 && phase_reg == 8'd0))
        else $error("frame state not cleared after last point");

    // a point that passes the pre-checks blocks the input while it is in work
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && keep_pre) |=> !s_ready)
        else $error("input ready while a point is in work");

endmodule
